>>> design/ssodo_pkg.sv
package ssodo_pkg;

	// Request codes
	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_VEL     = 2'd1,
		REQ_REFRESH = 2'd2,
		REQ_UNUSED  = 2'd3
	} ssodo_req_t;

	// Configuration register indexes
	localparam logic CFG_SKID_GAIN   = 1'b0;
	localparam logic CFG_CMD_TIMEOUT = 1'b1;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MW,
		ST_MPHI,
		ST_MDIST,
		ST_DECIDE,
		ST_H2,
		ST_H4,
		ST_D6,
		ST_D120,
		ST_LEN,
		ST_WRAP,
		ST_CORD,
		ST_VS,
		ST_DIV,
		ST_DX,
		ST_DY,
		ST_DONE
	} ssodo_state_t;

	// Angle constants: Q.16 heading, Q.30 CORDIC angles
	localparam logic signed [36:0] PI16      = 37'sd205887;
	localparam logic signed [36:0] TWO_PI16  = 37'sd411775;
	localparam logic signed [36:0] PI30      = 37'sd3373259426;
	localparam logic signed [36:0] TWO_PI30  = 37'sd6746518852;
	localparam logic signed [36:0] HALF_PI30 = 37'sd1686629713;
	localparam logic signed [33:0] CORDIC_K30 = 34'sd652032874;
	localparam int                 CORDIC_MAX = 24;

	// Motion thresholds
	localparam logic signed [31:0] STRAIGHT_LIMIT   = 32'sd134;
	localparam logic signed [36:0] SMALL_HALF_ANGLE = 37'sd268435456;
	localparam logic signed [32:0] ONE_Q30          = 33'sd1073741824;

	// Reciprocals (Q.32, rounded up) for exact floor division of short values
	localparam logic [31:0] RECIP_6   = 32'd715827883;
	localparam logic [31:0] RECIP_120 = 32'd35791395;

	// Divider: dividend width and last iteration
	localparam int          DIV_W    = 58;
	localparam logic [5:0]  DIV_LAST = 6'd57;

	// Arctangent of 2^-i in Q.30
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:    r = 30'd843314857;
			5'd1:    r = 30'd497837829;
			5'd2:    r = 30'd263043837;
			5'd3:    r = 30'd133525159;
			5'd4:    r = 30'd67021687;
			5'd5:    r = 30'd33543516;
			5'd6:    r = 30'd16775851;
			5'd7:    r = 30'd8388437;
			5'd8:    r = 30'd4194283;
			5'd9:    r = 30'd2097149;
			5'd10:   r = 30'd1048576;
			5'd11:   r = 30'd524288;
			5'd12:   r = 30'd262144;
			5'd13:   r = 30'd131072;
			5'd14:   r = 30'd65536;
			5'd15:   r = 30'd32768;
			5'd16:   r = 30'd16384;
			5'd17:   r = 30'd8192;
			5'd18:   r = 30'd4096;
			5'd19:   r = 30'd2048;
			5'd20:   r = 30'd1024;
			5'd21:   r = 30'd512;
			5'd22:   r = 30'd256;
			5'd23:   r = 30'd128;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

>>> design/ssodo_if.sv
interface ssodo_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [15:0] lin_vel;
	logic signed [15:0] ang_vel;
	logic [16:0]        tick_dt;

	modport source (output valid, req_type, lin_vel, ang_vel, tick_dt, input ready);
	modport sink (input valid, req_type, lin_vel, ang_vel, tick_dt, output ready);
endinterface

interface ssodo_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [18:0] heading;
	logic signed [15:0] speed;
	logic               watchdog_stop;
	logic               pose_valid;

	modport source (output valid, pos_x, pos_y, heading, speed, watchdog_stop, pose_valid,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading, speed, watchdog_stop, pose_valid,
		output ready);
endinterface

interface ssodo_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/skid_steer_odometry_integrator.sv
// Dead-reckoning odometry for a skid-steer base. Velocity and refresh requests are taken
// while idle and give no result. A tick gives one result; it is worked through one shared
// 35x35 multiplier, a one-step-per-cycle CORDIC and a one-bit-per-cycle divider under a
// sequencer, and the block takes no request until the tick is done. A tick with bad dt goes
// straight to its result; straight motion and a small arc each take one CORDIC pass plus
// angle wrapping; a large arc adds a second CORDIC pass, one product and a division. A
// finished result waits in the output register while the next request is taken.
// Configuration writes are taken in any cycle.
module skid_steer_odometry_integrator #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ssodo_req_if.sink   req,
	ssodo_res_if.source res,
	ssodo_cfg_if.sink   cfg
);

	localparam int CORDIC_N = (CORDIC_STEPS < ssodo_pkg::CORDIC_MAX) ?
		CORDIC_STEPS : ssodo_pkg::CORDIC_MAX;
	localparam int CNT_W = $clog2(CORDIC_N);
	localparam int DIVW = ssodo_pkg::DIV_W;

	ssodo_pkg::ssodo_state_t state_q, state_d;

	// Configuration and architectural state
	logic [15:0]        gain_q;
	logic [23:0]        timeout_q;
	logic signed [31:0] x_q, y_q;
	logic signed [18:0] theta_q;
	logic signed [15:0] speed_q, lin_q, ang_q;
	logic               active_q;
	logic [31:0]        since_q;

	// Per-tick working registers
	logic [16:0]        dt_q;
	logic               stop_q, valid_q;
	logic signed [31:0] w_q;
	logic signed [48:0] phi_q;
	logic signed [32:0] dist_q;
	logic signed [36:0] m_q;
	logic [25:0]        h2_q;
	logic [21:0]        h4_q;
	logic [31:0]        t6_q;
	logic signed [33:0] len_q;
	logic signed [36:0] acc_q;
	logic               mod16_q, phase_h_q, neg_q;
	logic signed [33:0] cx_q, cy_q, cz_q, sm_q;
	logic [CNT_W-1:0]   ci_q;
	logic [DIVW-1:0]    dq_q;
	logic [31:0]        rem_q, ud_q;
	logic [5:0]         dcnt_q;
	logic               dneg_q;

	// Shared multiplier
	logic signed [34:0] mul_a, mul_b;
	logic signed [69:0] prod_q;

	// Output register
	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic signed [18:0] out_head_q;
	logic signed [15:0] out_speed_q;
	logic               out_stop_q, out_pv_q;

	logic req_fire, out_free;
	assign req.ready = (state_q == ssodo_pkg::ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || res.ready;

	// Tick bookkeeping at the transfer
	logic [32:0] since_sum;
	logic [31:0] since_new;
	logic        stop_w, dt_ok;
	assign since_sum = {1'b0, since_q} + 33'(req.tick_dt);
	assign since_new = since_sum[32] ? '1 : since_sum[31:0];
	assign stop_w    = active_q && (since_new > {8'b0, timeout_q});
	assign dt_ok     = (req.tick_dt != 17'd0) && (req.tick_dt <= 17'd65536);

	// Arc decisions
	logic signed [36:0] h_w, th30_w;
	logic               is_straight, is_small;
	logic signed [32:0] dist_w;
	logic signed [33:0] dist_r;
	assign h_w         = 37'(phi_q >>> 14);
	assign th30_w      = {{4{theta_q[18]}}, theta_q, 14'b0};
	assign is_straight = (w_q <= ssodo_pkg::STRAIGHT_LIMIT) &&
		(w_q >= -ssodo_pkg::STRAIGHT_LIMIT);
	assign is_small    = (h_w < ssodo_pkg::SMALL_HALF_ANGLE) &&
		(h_w > -ssodo_pkg::SMALL_HALF_ANGLE);
	assign dist_w      = $signed(prod_q[32:0]);
	assign dist_r      = 34'(dist_w) + 34'sd8;

	// Series factor 1 - h^2/6 + h^4/120
	logic signed [32:0] f_w;
	assign f_w = ssodo_pkg::ONE_Q30 - $signed(33'(t6_q)) + $signed(33'(prod_q[63:32]));

	// Rounding shifts of the product
	logic signed [69:0] pr34, pr38;
	assign pr34 = prod_q + (70'sd1 <<< 33);
	assign pr38 = prod_q + (70'sd1 <<< 37);
	logic signed [48:0] phr;
	assign phr = phi_q + (49'sd1 <<< 26);

	// Angle wrap unit
	logic signed [36:0] wrap_mod, wrap_pi, a_w, fold_w;
	logic               wrap_ge, wrap_lt, fold_neg;
	assign wrap_mod = mod16_q ? ssodo_pkg::TWO_PI16 : ssodo_pkg::TWO_PI30;
	assign wrap_pi  = mod16_q ? ssodo_pkg::PI16 : ssodo_pkg::PI30;
	assign wrap_ge  = acc_q >= wrap_mod;
	assign wrap_lt  = acc_q < 37'sd0;
	assign a_w      = acc_q - wrap_pi;
	always_comb begin
		fold_w   = a_w;
		fold_neg = 1'b0;
		if (a_w > ssodo_pkg::HALF_PI30) begin
			fold_w   = a_w - ssodo_pkg::PI30;
			fold_neg = 1'b1;
		end else if (a_w < -ssodo_pkg::HALF_PI30) begin
			fold_w   = a_w + ssodo_pkg::PI30;
			fold_neg = 1'b1;
		end
	end

	// CORDIC step
	logic signed [33:0] xs, ys, at_w, nx, ny, nz, cos_w, sin_w;
	logic               cord_last;
	assign xs        = cx_q >>> ci_q;
	assign ys        = cy_q >>> ci_q;
	assign at_w      = $signed(34'(ssodo_pkg::atan_q30(5'(ci_q))));
	assign cord_last = (ci_q == CNT_W'(CORDIC_N - 1));
	always_comb begin
		if (!cz_q[33]) begin
			nx = cx_q - ys;
			ny = cy_q + xs;
			nz = cz_q - at_w;
		end else begin
			nx = cx_q + ys;
			ny = cy_q - xs;
			nz = cz_q + at_w;
		end
	end
	assign cos_w = neg_q ? -nx : nx;
	assign sin_w = neg_q ? -ny : ny;

	// Divider setup and step
	logic signed [57:0] numer_w;
	logic [57:0]        un_w;
	logic [31:0]        ud_w;
	logic [32:0]        trial;
	logic               qbit;
	logic [57:0]        dq_next;
	logic signed [33:0] quot_w;
	assign numer_w = 58'(prod_q) <<< 10;
	assign un_w    = numer_w[57] ? 58'(-numer_w) : 58'(numer_w);
	assign ud_w    = w_q[31] ? 32'(-w_q) : 32'(w_q);
	assign trial   = {rem_q, dq_q[DIVW-1]};
	assign qbit    = trial >= {1'b0, ud_q};
	assign dq_next = {dq_q[DIVW-2:0], qbit};
	assign quot_w  = dneg_q ? -$signed(34'(dq_next)) : $signed(34'(dq_next));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssodo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			ssodo_pkg::ST_IDLE: begin
				if (req_fire && req.req_type == ssodo_pkg::REQ_TICK) begin
					state_d = dt_ok ? ssodo_pkg::ST_MW : ssodo_pkg::ST_DONE;
				end
			end
			ssodo_pkg::ST_MW: begin
				mul_a   = 35'(ang_q);
				mul_b   = 35'(gain_q);
				state_d = ssodo_pkg::ST_MPHI;
			end
			ssodo_pkg::ST_MPHI: begin
				mul_a   = 35'($signed(prod_q[31:0]));
				mul_b   = 35'(dt_q);
				state_d = ssodo_pkg::ST_MDIST;
			end
			ssodo_pkg::ST_MDIST: begin
				mul_a   = 35'(lin_q);
				mul_b   = 35'(dt_q);
				state_d = ssodo_pkg::ST_DECIDE;
			end
			ssodo_pkg::ST_DECIDE: begin
				if (is_straight) begin
					state_d = ssodo_pkg::ST_WRAP;
				end else if (is_small) begin
					mul_a   = 35'(h_w);
					mul_b   = 35'(h_w);
					state_d = ssodo_pkg::ST_H2;
				end else begin
					state_d = ssodo_pkg::ST_WRAP;
				end
			end
			ssodo_pkg::ST_H2: begin
				mul_a   = 35'(prod_q[55:30]);
				mul_b   = 35'(prod_q[55:30]);
				state_d = ssodo_pkg::ST_H4;
			end
			ssodo_pkg::ST_H4: begin
				mul_a   = 35'(h2_q);
				mul_b   = 35'(ssodo_pkg::RECIP_6);
				state_d = ssodo_pkg::ST_D6;
			end
			ssodo_pkg::ST_D6: begin
				mul_a   = 35'(h4_q);
				mul_b   = 35'(ssodo_pkg::RECIP_120);
				state_d = ssodo_pkg::ST_D120;
			end
			ssodo_pkg::ST_D120: begin
				mul_a   = 35'(dist_q);
				mul_b   = 35'(f_w);
				state_d = ssodo_pkg::ST_LEN;
			end
			ssodo_pkg::ST_LEN: begin
				state_d = ssodo_pkg::ST_WRAP;
			end
			ssodo_pkg::ST_WRAP: begin
				if (!wrap_ge && !wrap_lt) begin
					state_d = mod16_q ? ssodo_pkg::ST_DONE : ssodo_pkg::ST_CORD;
				end
			end
			ssodo_pkg::ST_CORD: begin
				if (cord_last) begin
					if (phase_h_q) begin
						mul_a   = 35'(lin_q);
						mul_b   = 35'(sin_w);
						state_d = ssodo_pkg::ST_VS;
					end else begin
						mul_a   = 35'(len_q);
						mul_b   = 35'(cos_w);
						state_d = ssodo_pkg::ST_DX;
					end
				end
			end
			ssodo_pkg::ST_VS: begin
				state_d = ssodo_pkg::ST_DIV;
			end
			ssodo_pkg::ST_DIV: begin
				if (dcnt_q == ssodo_pkg::DIV_LAST) begin
					state_d = ssodo_pkg::ST_WRAP;
				end
			end
			ssodo_pkg::ST_DX: begin
				mul_a   = 35'(len_q);
				mul_b   = 35'(sm_q);
				state_d = ssodo_pkg::ST_DY;
			end
			ssodo_pkg::ST_DY: begin
				state_d = ssodo_pkg::ST_WRAP;
			end
			ssodo_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ssodo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ssodo_pkg::ST_IDLE;
			end
		endcase
	end

	// Register the product every cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Configuration, pose and command state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= 16'd22938;
			timeout_q <= 24'd65536;
			x_q       <= '0;
			y_q       <= '0;
			theta_q   <= '0;
			speed_q   <= '0;
			lin_q     <= '0;
			ang_q     <= '0;
			active_q  <= 1'b0;
			since_q   <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					ssodo_pkg::CFG_SKID_GAIN:   gain_q    <= cfg.data[15:0];
					ssodo_pkg::CFG_CMD_TIMEOUT: timeout_q <= cfg.data;
					default: ;
				endcase
			end
			if (req_fire) begin
				case (req.req_type)
					ssodo_pkg::REQ_TICK: begin
						since_q <= since_new;
						if (stop_w) begin
							lin_q    <= '0;
							ang_q    <= '0;
							active_q <= 1'b0;
						end
					end
					ssodo_pkg::REQ_VEL: begin
						lin_q    <= req.lin_vel;
						ang_q    <= req.ang_vel;
						since_q  <= '0;
						active_q <= 1'b1;
					end
					ssodo_pkg::REQ_REFRESH: begin
						since_q <= '0;
					end
					default: ;
				endcase
			end
			// Commit position, heading and speed
			if (state_q == ssodo_pkg::ST_DX) begin
				x_q <= x_q + $signed(pr38[69:38] );
			end
			if (state_q == ssodo_pkg::ST_DY) begin
				y_q <= y_q + $signed(pr38[69:38]);
			end
			if (state_q == ssodo_pkg::ST_WRAP && mod16_q && !wrap_ge && !wrap_lt) begin
				theta_q <= 19'(a_w);
				speed_q <= lin_q;
			end
		end
	end

	// Working registers of the tick
	always_ff @(posedge clk) begin
		case (state_q)
			ssodo_pkg::ST_IDLE: begin
				stop_q  <= stop_w;
				valid_q <= dt_ok;
				dt_q    <= req.tick_dt;
			end
			ssodo_pkg::ST_MPHI: begin
				w_q <= $signed(prod_q[31:0]);
			end
			ssodo_pkg::ST_MDIST: begin
				phi_q <= $signed(prod_q[48:0]);
			end
			ssodo_pkg::ST_DECIDE: begin
				dist_q <= dist_w;
				m_q    <= th30_w + h_w;
				if (is_straight) begin
					len_q     <= dist_r >>> 4;
					acc_q     <= th30_w + ssodo_pkg::PI30;
					mod16_q   <= 1'b0;
					phase_h_q <= 1'b0;
				end else if (!is_small) begin
					acc_q     <= h_w + ssodo_pkg::PI30;
					mod16_q   <= 1'b0;
					phase_h_q <= 1'b1;
				end
			end
			ssodo_pkg::ST_H2: begin
				h2_q <= prod_q[55:30];
			end
			ssodo_pkg::ST_H4: begin
				h4_q <= prod_q[51:30];
			end
			ssodo_pkg::ST_D6: begin
				t6_q <= prod_q[63:32];
			end
			ssodo_pkg::ST_LEN: begin
				len_q     <= $signed(pr34[67:34]);
				acc_q     <= m_q + ssodo_pkg::PI30;
				mod16_q   <= 1'b0;
				phase_h_q <= 1'b0;
			end
			ssodo_pkg::ST_WRAP: begin
				// Reduce into [0, 2pi), then fold into [-pi/2, pi/2] for the CORDIC
				if (wrap_ge) begin
					acc_q <= acc_q - wrap_mod;
				end else if (wrap_lt) begin
					acc_q <= acc_q + wrap_mod;
				end else begin
					cx_q  <= ssodo_pkg::CORDIC_K30;
					cy_q  <= '0;
					cz_q  <= 34'(fold_w);
					neg_q <= fold_neg;
					ci_q  <= '0;
				end
			end
			ssodo_pkg::ST_CORD: begin
				cx_q <= nx;
				cy_q <= ny;
				cz_q <= nz;
				ci_q <= ci_q + 1'b1;
				if (cord_last && !phase_h_q) begin
					sm_q <= sin_w;
				end
			end
			ssodo_pkg::ST_VS: begin
				dq_q   <= un_w + 58'(ud_w >> 1);
				rem_q  <= '0;
				ud_q   <= ud_w;
				dcnt_q <= '0;
				dneg_q <= numer_w[57] ^ w_q[31];
			end
			ssodo_pkg::ST_DIV: begin
				rem_q  <= qbit ? 32'(trial - {1'b0, ud_q}) : trial[31:0];
				dq_q   <= dq_next;
				dcnt_q <= dcnt_q + 6'd1;
				if (dcnt_q == ssodo_pkg::DIV_LAST) begin
					len_q     <= quot_w;
					acc_q     <= m_q + ssodo_pkg::PI30;
					mod16_q   <= 1'b0;
					phase_h_q <= 1'b0;
				end
			end
			ssodo_pkg::ST_DY: begin
				acc_q   <= 37'(theta_q) + 37'(phr >>> 27) + ssodo_pkg::PI16;
				mod16_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// Output register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ssodo_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ssodo_pkg::ST_DONE && out_free) begin
			out_x_q     <= x_q;
			out_y_q     <= y_q;
			out_head_q  <= theta_q;
			out_speed_q <= speed_q;
			out_stop_q  <= stop_q;
			out_pv_q    <= valid_q;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.pos_x         = out_x_q;
	assign res.pos_y         = out_y_q;
	assign res.heading       = out_head_q;
	assign res.speed         = out_speed_q;
	assign res.watchdog_stop = out_stop_q;
	assign res.pose_valid    = out_pv_q;

endmodule

>>> design/ssodo_checker.sv
module ssodo_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic [1:0]         req_type,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [31:0] pos_x,
	input logic signed [18:0] heading,
	input logic signed [15:0] speed,
	input logic               watchdog_stop,
	input logic               pose_valid
);

	// A waiting result holds until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(pos_x) && $stable(heading))
		else $error("result dropped or changed while stalled");

	// A tick occupies the block after its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == ssodo_pkg::REQ_TICK |=> !req_ready)
		else $error("request taken during a tick");

	// Heading stays wrapped to plus or minus pi
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> heading <= 19'sd205887 && heading >= -19'sd205887)
		else $error("heading out of range");

	// A stop on an integrated tick leaves zero speed
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && watchdog_stop && pose_valid |-> speed == 16'sd0)
		else $error("speed not zero after watchdog stop");

	// Command and refresh requests produce no result
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type != ssodo_pkg::REQ_TICK |=> !$rose(res_valid))
		else $error("result produced by a non-tick request");

endmodule

bind skid_steer_odometry_integrator ssodo_checker u_ssodo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_type      (req.req_type),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.pos_x         (res.pos_x),
	.heading       (res.heading),
	.speed         (res.speed),
	.watchdog_stop (res.watchdog_stop),
	.pose_valid    (res.pose_valid)
);
